// ----- hdl/msde_pkg.sv -----
// Shared types and constants for the MIPS subset decode and execute core.
// Holds opcode and function codes and the execute result record; no dependencies.
package msde_pkg;

    localparam int WordW = 32;
    localparam int RegW  = 5;

    typedef logic [WordW-1:0] word_t;
    typedef logic [RegW-1:0]  reg_idx_t;
    typedef logic [5:0]       opcode_t;
    typedef logic [5:0]       funct_t;

    localparam opcode_t OP_SPECIAL = 6'd0;
    localparam opcode_t OP_J       = 6'd2;
    localparam opcode_t OP_JAL     = 6'd3;
    localparam opcode_t OP_BEQ     = 6'd4;
    localparam opcode_t OP_BNE     = 6'd5;
    localparam opcode_t OP_BGTZ    = 6'd7;
    localparam opcode_t OP_ADDI    = 6'd8;
    localparam opcode_t OP_ADDIU   = 6'd9;
    localparam opcode_t OP_SLTI    = 6'd10;
    localparam opcode_t OP_ORI     = 6'd13;
    localparam opcode_t OP_LUI     = 6'd15;
    localparam opcode_t OP_LW      = 6'd35;
    localparam opcode_t OP_SW      = 6'd43;

    localparam funct_t FN_ADD  = 6'd32;
    localparam funct_t FN_ADDU = 6'd33;
    localparam funct_t FN_SUB  = 6'd34;
    localparam funct_t FN_SUBU = 6'd35;
    localparam funct_t FN_SLT  = 6'd42;
    localparam funct_t FN_SLTU = 6'd43;

    localparam word_t JUMP_REGION_MASK = 32'hF000_0000;

    typedef struct packed {
        word_t    result;
        logic     write_enable;
        reg_idx_t dest_reg;
        logic     mem_read;
        logic     mem_write;
        word_t    store_data;
        logic     redirect;
        word_t    target;
        logic     illegal;
    } exec_res_t;

endpackage

// ----- hdl/msde_exec.sv -----
// Decode and execute logic for one instruction, purely combinational.
// Depends on msde_pkg for opcode codes and the result record.
module msde_exec (
    input  msde_pkg::word_t     instruction,
    input  msde_pkg::word_t     pc,
    input  msde_pkg::word_t     rs_value,
    input  msde_pkg::word_t     rt_value,
    output msde_pkg::exec_res_t res
);
    import msde_pkg::*;

    opcode_t  op;
    funct_t   fn;
    reg_idx_t rt;
    reg_idx_t rd;
    word_t    imm;
    word_t    simm;
    word_t    pc_plus4;
    word_t    btarget;
    word_t    jtarget;
    logic     slt_s;
    logic     slti_s;
    logic     gtz_s;

    assign op       = instruction[31:26];
    assign fn       = instruction[5:0];
    assign rt       = instruction[20:16];
    assign rd       = instruction[15:11];
    assign imm      = {16'd0, instruction[15:0]};
    assign simm     = {{16{instruction[15]}}, instruction[15:0]};
    assign pc_plus4 = pc + 32'd4;
    assign btarget  = pc_plus4 + {simm[29:0], 2'b00};
    assign jtarget  = (pc_plus4 & JUMP_REGION_MASK) | {4'd0, instruction[25:0], 2'b00};
    assign slt_s    = $signed(rs_value) < $signed(rt_value);
    assign slti_s   = $signed(rs_value) < $signed(simm);
    assign gtz_s    = $signed(rs_value) > $signed(32'sd0);

    always_comb begin
        res = '0;
        if (instruction == '0) begin
            res = '0;
        end else if (op == OP_SPECIAL) begin
            unique case (fn) inside
                FN_ADD, FN_ADDU: begin
                    res.result       = rs_value + rt_value;
                    res.write_enable = 1'b1;
                    res.dest_reg     = rd;
                end
                FN_SUB, FN_SUBU: begin
                    res.result       = rs_value - rt_value;
                    res.write_enable = 1'b1;
                    res.dest_reg     = rd;
                end
                FN_SLT: begin
                    res.result       = {31'd0, slt_s};
                    res.write_enable = 1'b1;
                    res.dest_reg     = rd;
                end
                FN_SLTU: begin
                    res.result       = {31'd0, rs_value < rt_value};
                    res.write_enable = 1'b1;
                    res.dest_reg     = rd;
                end
                default: begin
                    res.illegal = 1'b1;
                end
            endcase
        end else begin
            unique case (op) inside
                OP_J, OP_JAL: begin
                    res.redirect = 1'b1;
                    res.target   = jtarget;
                end
                OP_BEQ: begin
                    res.dest_reg = rt;
                    res.redirect = (rs_value == rt_value);
                    res.target   = (rs_value == rt_value) ? btarget : '0;
                end
                OP_BNE: begin
                    res.dest_reg = rt;
                    res.redirect = (rs_value != rt_value);
                    res.target   = (rs_value != rt_value) ? btarget : '0;
                end
                OP_BGTZ: begin
                    res.dest_reg = rt;
                    res.redirect = gtz_s;
                    res.target   = gtz_s ? btarget : '0;
                end
                OP_ADDI, OP_ADDIU: begin
                    res.result       = rs_value + simm;
                    res.write_enable = 1'b1;
                    res.dest_reg     = rt;
                end
                OP_SLTI: begin
                    res.result       = {31'd0, slti_s};
                    res.write_enable = 1'b1;
                    res.dest_reg     = rt;
                end
                OP_ORI: begin
                    res.result       = rs_value | imm;
                    res.write_enable = 1'b1;
                    res.dest_reg     = rt;
                end
                OP_LUI: begin
                    res.result       = {instruction[15:0], 16'd0};
                    res.write_enable = 1'b1;
                    res.dest_reg     = rt;
                end
                OP_LW: begin
                    res.result       = rs_value + simm;
                    res.write_enable = 1'b1;
                    res.mem_read     = 1'b1;
                    res.dest_reg     = rt;
                end
                OP_SW: begin
                    res.result     = rs_value + simm;
                    res.mem_write  = 1'b1;
                    res.store_data = rt_value;
                    res.dest_reg   = rt;
                end
                default: begin
                    res.illegal = 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- hdl/mips_subset_decode_execute_core.sv -----
// Top level of the MIPS subset decode and execute core: input and result registers.
// Depends on msde_pkg and msde_exec.
//
// The core takes one instruction beat per clock while not stalled and returns one result
// beat for each. A beat is captured into an input register, decoded and executed by a
// single pass of logic, and captured into the result register. With m_tready held high
// the core sustains one beat per cycle; when the downstream side stalls, both registers
// fill and s_tready drops until a result is taken.
module mips_subset_decode_execute_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // instruction [31:0], pc [63:32], rs_value [95:64], rt_value [127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result [31:0], write_enable [32], dest_reg [37:33], mem_read [38],
    // mem_write [39], store_data [71:40], redirect [72], target [104:73], zero pad above
    output logic [111:0] m_tdata,
    // illegal [0]
    output logic [0:0]   m_tuser
);
    import msde_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    word_t     ins_reg;
    word_t     pc_reg;
    word_t     rs_reg;
    word_t     rt_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    exec_res_t out_reg;
    exec_res_t exec_res;
    logic      out_load;
    logic      in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            ins_reg <= s_tdata[31:0];
            pc_reg  <= s_tdata[63:32];
            rs_reg  <= s_tdata[95:64];
            rt_reg  <= s_tdata[127:96];
        end
        if (out_load) begin
            out_reg <= exec_res;
        end
    end

    msde_exec u_exec (
        .instruction (ins_reg),
        .pc          (pc_reg),
        .rs_value    (rs_reg),
        .rt_value    (rt_reg),
        .res         (exec_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.target, out_reg.redirect, out_reg.store_data,
                       out_reg.mem_write, out_reg.mem_read, out_reg.dest_reg,
                       out_reg.write_enable, out_reg.result};
    assign m_tuser  = out_reg.illegal;

endmodule
